FILE: hw/rtl/bal_pkg.sv
package bal_pkg;

   localparam int DATA_WIDTH     = 8;
   localparam int CNT_WIDTH      = $clog2(DATA_WIDTH);
   localparam int REG_COUNT      = 4;
   localparam int REG_ADDR_WIDTH = $clog2(REG_COUNT);
   localparam int BYTE_WIDTH     = 8;

   localparam logic [REG_ADDR_WIDTH-1:0] REM_REG = REG_ADDR_WIDTH'(REG_COUNT - 1);

   typedef enum logic [2:0] {
      OP_MOVE = 3'd0,
      OP_ADD  = 3'd1,
      OP_MUL  = 3'd2,
      OP_DIV  = 3'd3,
      OP_SUB  = 3'd4,
      OP_NOT  = 3'd5,
      OP_OR   = 3'd6,
      OP_AND  = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_EXEC,
      ST_WRREM,
      ST_DONE
   } state_type;

   typedef struct packed {
      op_type                    op;
      logic [REG_ADDR_WIDTH-1:0] target_reg;
      logic [REG_ADDR_WIDTH-1:0] source_reg;
      logic                      use_immediate;
      logic [BYTE_WIDTH-1:0]     immediate;
   } req_type;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] written_value;
      logic [BYTE_WIDTH-1:0] remainder;
      logic                  divide_by_zero;
   } rsp_type;

   typedef struct packed {
      op_type                op;
      logic [DATA_WIDTH-1:0] a;
      logic [DATA_WIDTH-1:0] b;
   } alu_cmd_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] result;
      logic [DATA_WIDTH-1:0] remainder;
      logic                  div_by_zero;
   } alu_res_type;

   typedef struct packed {
      logic                      en;
      logic [REG_ADDR_WIDTH-1:0] addr;
      logic [DATA_WIDTH-1:0]     data;
   } rf_wr_type;

endpackage

FILE: hw/rtl/bal_regfile.sv
module bal_regfile (
   input  logic                               clock,
   input  logic                               reset,
   input  bal_pkg::rf_wr_type                 wr,
   input  logic [bal_pkg::REG_ADDR_WIDTH-1:0] rd_addr_a,
   input  logic [bal_pkg::REG_ADDR_WIDTH-1:0] rd_addr_b,
   output logic [bal_pkg::DATA_WIDTH-1:0]     rd_data_a,
   output logic [bal_pkg::DATA_WIDTH-1:0]     rd_data_b
);

   logic [bal_pkg::DATA_WIDTH-1:0] mem_ff [bal_pkg::REG_COUNT];
   logic [bal_pkg::REG_COUNT-1:0]  valid_ff;
   logic [bal_pkg::REG_COUNT-1:0]  valid_in;
   logic [bal_pkg::DATA_WIDTH-1:0] rd_a_ff;
   logic [bal_pkg::DATA_WIDTH-1:0] rd_b_ff;
   logic                           rd_a_valid_ff;
   logic                           rd_b_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      rd_a_ff       <= mem_ff[rd_addr_a];
      rd_b_ff       <= mem_ff[rd_addr_b];
      rd_a_valid_ff <= valid_ff[rd_addr_a];
      rd_b_valid_ff <= valid_ff[rd_addr_b];
   end

   // entries never written read as zero
   assign rd_data_a = rd_a_valid_ff ? rd_a_ff : '0;
   assign rd_data_b = rd_b_valid_ff ? rd_b_ff : '0;

endmodule

FILE: hw/rtl/bal_alu_unit.sv
module bal_alu_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  bal_pkg::alu_cmd_type cmd,
   output logic                 done,
   output bal_pkg::alu_res_type res
);

   localparam int W = bal_pkg::DATA_WIDTH;

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   bal_pkg::op_type               op_ff, op_in;
   logic [bal_pkg::CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [W-1:0]                  x_ff, x_in;
   logic [W-1:0]                  y_ff, y_in;
   logic [W-1:0]                  z_ff, z_in;
   bal_pkg::alu_res_type          res_ff, res_in;
   logic [W:0]                    add_x;
   logic [W:0]                    add_y;
   logic                          add_sub;
   logic [W:0]                    sum;

   // shared adder / subtractor
   always_comb begin
      if (busy_ff && op_ff == bal_pkg::OP_MUL) begin
         add_x   = {1'b0, x_ff};
         add_y   = z_ff[0] ? {1'b0, y_ff} : '0;
         add_sub = 1'b0;
      end else if (busy_ff) begin
         add_x   = {x_ff, z_ff[W-1]};
         add_y   = {1'b0, y_ff};
         add_sub = 1'b1;
      end else begin
         add_x   = {1'b0, cmd.a};
         add_y   = {1'b0, cmd.b};
         add_sub = (cmd.op == bal_pkg::OP_SUB);
      end
      sum = add_x + (add_sub ? ~add_y : add_y) + (W+1)'(add_sub);
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      res_in  = res_ff;
      if (busy_ff) begin
         if (op_ff == bal_pkg::OP_MUL) begin
            // shift-add multiply
            x_in = sum[W-1:0];
            y_in = y_ff << 1;
            z_in = z_ff >> 1;
         end else begin
            // restoring divide, one quotient bit a step
            if (!sum[W]) begin
               x_in = sum[W-1:0];
               z_in = {z_ff[W-2:0], 1'b1};
            end else begin
               x_in = add_x[W-1:0];
               z_in = {z_ff[W-2:0], 1'b0};
            end
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in            = 1'b0;
            done_in            = 1'b1;
            res_in.div_by_zero = 1'b0;
            if (op_ff == bal_pkg::OP_MUL) begin
               res_in.result    = x_in;
               res_in.remainder = '0;
            end else begin
               res_in.result    = z_in;
               res_in.remainder = x_in;
            end
         end
      end else if (start) begin
         op_in              = cmd.op;
         res_in.remainder   = '0;
         res_in.div_by_zero = 1'b0;
         case (cmd.op)
            bal_pkg::OP_MUL: begin
               busy_in = 1'b1;
               cnt_in  = bal_pkg::CNT_WIDTH'(W - 1);
               x_in    = '0;
               y_in    = cmd.a;
               z_in    = cmd.b;
            end
            bal_pkg::OP_DIV: begin
               if (cmd.b == '0) begin
                  done_in            = 1'b1;
                  res_in.result      = cmd.a;
                  res_in.div_by_zero = 1'b1;
               end else begin
                  busy_in = 1'b1;
                  cnt_in  = bal_pkg::CNT_WIDTH'(W - 1);
                  x_in    = '0;
                  y_in    = cmd.b;
                  z_in    = cmd.a;
               end
            end
            bal_pkg::OP_MOVE: begin
               done_in       = 1'b1;
               res_in.result = cmd.b;
            end
            bal_pkg::OP_ADD, bal_pkg::OP_SUB: begin
               done_in       = 1'b1;
               res_in.result = sum[W-1:0];
            end
            bal_pkg::OP_NOT: begin
               done_in       = 1'b1;
               res_in.result = ~cmd.a;
            end
            bal_pkg::OP_OR: begin
               done_in       = 1'b1;
               res_in.result = cmd.a | cmd.b;
            end
            default: begin
               done_in       = 1'b1;
               res_in.result = cmd.a & cmd.b;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      res_ff <= res_in;
   end

   assign done = done_ff;
   assign res  = res_ff;

endmodule

FILE: hw/rtl/byte_alu_with_register_file_top.sv
// channel | direction | handshake             | payload
// req     | in        | req_valid / req_ready | req_data (bal_pkg::req_type)
// rsp     | out       | rsp_valid / rsp_ready | rsp_data (bal_pkg::rsp_type)
//
// one transaction at a time; req_ready is high only while idle
// after accept: LOAD reads the registers, EXEC runs the alu and writes the target
// (not on a zero divisor), WRREM writes the remainder after a divide, DONE registers
// the response; multiply and divide step the shared adder one bit a cycle
// reset clears the four registers to zero through per-entry valid bits
// a stalled rsp holds in the output register; the next req is taken meanwhile
module byte_alu_with_register_file_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bal_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bal_pkg::rsp_type rsp_data
);

   bal_pkg::state_type             state_ff, state_in;
   bal_pkg::req_type               req_ff, req_in;
   bal_pkg::alu_res_type           work_ff, work_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   bal_pkg::rsp_type               rsp_data_ff, rsp_data_in;
   bal_pkg::rf_wr_type             rf_wr;
   logic [bal_pkg::DATA_WIDTH-1:0] rd_a;
   logic [bal_pkg::DATA_WIDTH-1:0] rd_b;
   logic                           u_start;
   bal_pkg::alu_cmd_type           u_cmd;
   logic                           u_done;
   bal_pkg::alu_res_type           u_res;
   logic                           rem_to_target;

   bal_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .wr        (rf_wr),
      .rd_addr_a (req_data.target_reg),
      .rd_addr_b (req_data.source_reg),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   bal_alu_unit u_alu (
      .clock (clock),
      .reset (reset),
      .start (u_start),
      .cmd   (u_cmd),
      .done  (u_done),
      .res   (u_res)
   );

   assign req_ready = (state_ff == bal_pkg::ST_IDLE);
   assign u_start   = (state_ff == bal_pkg::ST_LOAD);

   always_comb begin
      u_cmd.op = req_ff.op;
      u_cmd.a  = rd_a;
      u_cmd.b  = req_ff.use_immediate ?
                 bal_pkg::DATA_WIDTH'(req_ff.immediate) : rd_b;
   end

   // divide into the remainder register leaves the remainder there
   assign rem_to_target = (req_ff.op == bal_pkg::OP_DIV) && !work_ff.div_by_zero &&
                          (req_ff.target_reg == bal_pkg::REM_REG);

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      work_in      = work_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      rf_wr.en     = 1'b0;
      rf_wr.addr   = req_ff.target_reg;
      rf_wr.data   = u_res.result;
      case (state_ff)
         bal_pkg::ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = bal_pkg::ST_LOAD;
            end
         end
         bal_pkg::ST_LOAD: begin
            state_in = bal_pkg::ST_EXEC;
         end
         bal_pkg::ST_EXEC: begin
            if (u_done) begin
               work_in  = u_res;
               rf_wr.en = !u_res.div_by_zero;
               if (req_ff.op == bal_pkg::OP_DIV && !u_res.div_by_zero) begin
                  state_in = bal_pkg::ST_WRREM;
               end else begin
                  state_in = bal_pkg::ST_DONE;
               end
            end
         end
         bal_pkg::ST_WRREM: begin
            rf_wr.en   = 1'b1;
            rf_wr.addr = bal_pkg::REM_REG;
            rf_wr.data = work_ff.remainder;
            state_in   = bal_pkg::ST_DONE;
         end
         bal_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.written_value  = bal_pkg::BYTE_WIDTH'(rem_to_target ?
                                            work_ff.remainder : work_ff.result);
               rsp_data_in.remainder      = bal_pkg::BYTE_WIDTH'(work_ff.remainder);
               rsp_data_in.divide_by_zero = work_ff.div_by_zero;
               state_in                   = bal_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bal_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bal_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      work_ff     <= work_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_done_in_exec : assert property (@(posedge clock) disable iff (reset)
      u_done |-> state_ff == bal_pkg::ST_EXEC)
      else $error("alu result outside execute");

   a_no_write_when_idle : assert property (@(posedge clock) disable iff (reset)
      rf_wr.en |-> !req_ready)
      else $error("register write while idle");

   a_accept_loads : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == bal_pkg::ST_LOAD)
      else $error("accepted transaction not loaded");

   a_dz_no_remainder : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.divide_by_zero |-> rsp_data.remainder == '0)
      else $error("remainder on zero divisor");

   a_rem_write_after_div : assert property (@(posedge clock) disable iff (reset)
      state_ff == bal_pkg::ST_WRREM |-> $past(u_done) && req_ff.op == bal_pkg::OP_DIV)
      else $error("remainder write without divide");
`endif

endmodule

FILE: dv/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bal_pkg::*;

   localparam int NUM_RANDOM  = 1200;
   localparam int IDLE_LIMIT  = 3000;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_WAIT  = 20;

   class register_file_model;
      logic [DATA_WIDTH-1:0] regs [REG_COUNT];
      rsp_type pending_results[$];
      int errors;
      int executed;
      int checked;
      int div_zero_count;
      int op_count [8];

      function new();
         foreach (regs[i]) regs[i] = '0;
         errors = 0;
         executed = 0;
         checked = 0;
         div_zero_count = 0;
         foreach (op_count[i]) op_count[i] = 0;
      endfunction

      function void execute(req_type r);
         logic [DATA_WIDTH-1:0] a, b, res, rem_v;
         rsp_type e;
         a = regs[r.target_reg];
         b = r.use_immediate ? DATA_WIDTH'(r.immediate) : regs[r.source_reg];
         res = a;
         e = '0;
         case (r.op)
            OP_MOVE: res = b;
            OP_ADD:  res = a + b;
            OP_MUL:  res = a * b;
            OP_DIV: begin
               if (b == '0) begin
                  e.divide_by_zero = 1'b1;
                  div_zero_count++;
               end else begin
                  res = a / b;
                  rem_v = a % b;
                  regs[r.target_reg] = res;
                  regs[REM_REG] = rem_v;
                  e.remainder = BYTE_WIDTH'(rem_v);
               end
            end
            OP_SUB:  res = a - b;
            OP_NOT:  res = ~a;
            OP_OR:   res = a | b;
            default: res = a & b;
         endcase
         if (r.op != OP_DIV) regs[r.target_reg] = res;
         e.written_value = BYTE_WIDTH'(regs[r.target_reg]);
         pending_results.push_back(e);
         op_count[r.op]++;
         executed++;
      endfunction

      function void compare(rsp_type got);
         rsp_type e;
         if (pending_results.size() == 0) begin
            $error("result with no instruction outstanding: %p", got);
            errors++;
            return;
         end
         e = pending_results.pop_front();
         checked++;
         if (got.written_value !== e.written_value) begin
            $error("written_value: expected %0d, got %0d", e.written_value, got.written_value);
            errors++;
         end
         if (got.remainder !== e.remainder) begin
            $error("remainder: expected %0d, got %0d", e.remainder, got.remainder);
            errors++;
         end
         if (got.divide_by_zero !== e.divide_by_zero) begin
            $error("divide_by_zero: expected %0b, got %0b", e.divide_by_zero,
                   got.divide_by_zero);
            errors++;
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   register_file_model model = new();
   req_type program_q[$];
   int      num_directed;
   int      idle_cycles = 0;
   bit      held_off = 1'b0;

   byte_alu_with_register_file_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic req_type instr(op_type op, int tgt, int src, bit imm, int value);
      req_type r;
      r.op = op;
      r.target_reg = REG_ADDR_WIDTH'(tgt);
      r.source_reg = REG_ADDR_WIDTH'(src);
      r.use_immediate = imm;
      r.immediate = BYTE_WIDTH'(value);
      return r;
   endfunction

   function automatic req_type random_instr();
      req_type r;
      int pick;
      r.target_reg = REG_ADDR_WIDTH'($urandom_range(0, REG_COUNT - 1));
      r.source_reg = REG_ADDR_WIDTH'($urandom_range(0, REG_COUNT - 1));
      r.use_immediate = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
         r.op = OP_MOVE;
         r.use_immediate = 1'b1;
      end else begin
         r.op = op_type'($urandom_range(0, 7));
      end
      pick = $urandom_range(0, 7);
      if (pick == 0) r.immediate = '0;
      else if (pick == 1) r.immediate = '1;
      else if (pick == 2) r.immediate = 8'd1;
      else r.immediate = BYTE_WIDTH'($urandom_range(0, 255));
      return r;
   endfunction

   task automatic offer(input req_type r);
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drive_program();
      int idx;
      int burst;
      int gap;
      idx = 0;
      while (idx < program_q.size()) begin
         burst = $urandom_range(1, 24);
         for (int k = 0; k < burst && idx < program_q.size(); k++) begin
            offer(program_q[idx]);
            idx++;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b0;
   endtask

   // directed: wrap-around, divide special cases, operand ignored by not
   initial begin
      program_q.push_back(instr(OP_MOVE, 0, 0, 1, 255));
      program_q.push_back(instr(OP_MOVE, 1, 0, 1, 1));
      program_q.push_back(instr(OP_ADD,  0, 1, 0, 0));
      program_q.push_back(instr(OP_MOVE, 2, 3, 1, 0));
      program_q.push_back(instr(OP_SUB,  2, 0, 1, 1));
      program_q.push_back(instr(OP_MUL,  2, 2, 0, 0));
      program_q.push_back(instr(OP_MOVE, 0, 1, 1, 200));
      program_q.push_back(instr(OP_DIV,  0, 2, 1, 7));
      program_q.push_back(instr(OP_DIV,  1, 2, 1, 0));
      program_q.push_back(instr(OP_DIV,  0, 3, 0, 0));
      program_q.push_back(instr(OP_MOVE, 3, 0, 1, 250));
      program_q.push_back(instr(OP_DIV,  3, 0, 1, 9));
      program_q.push_back(instr(OP_DIV,  3, 3, 0, 0));
      program_q.push_back(instr(OP_DIV,  0, 3, 0, 0));
      program_q.push_back(instr(OP_NOT,  1, 2, 1, 8'hAA));
      program_q.push_back(instr(OP_NOT,  3, 1, 0, 0));
      program_q.push_back(instr(OP_OR,   0, 0, 1, 8'hF0));
      program_q.push_back(instr(OP_AND,  0, 0, 1, 8'h3C));
      program_q.push_back(instr(OP_MOVE, 1, 0, 0, 0));
      program_q.push_back(instr(OP_MUL,  1, 0, 1, 255));
      program_q.push_back(instr(OP_ADD,  2, 0, 1, 255));
      program_q.push_back(instr(OP_SUB,  0, 0, 0, 0));
      program_q.push_back(instr(OP_MOVE, 2, 0, 1, 8'h55));
      program_q.push_back(instr(OP_OR,   2, 1, 0, 0));
      program_q.push_back(instr(OP_AND,  3, 2, 1, 0));
      num_directed = program_q.size();
      repeat (NUM_RANDOM) program_q.push_back(random_instr());

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      drive_program();
      @(posedge clock);
      while (model.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("%0d instructions run (%0d directed), %0d results checked",
               model.executed, num_directed, model.checked);
      $display("mix: move %0d add %0d mul %0d div %0d (%0d by zero) sub %0d not %0d or %0d and %0d",
               model.op_count[OP_MOVE], model.op_count[OP_ADD], model.op_count[OP_MUL],
               model.op_count[OP_DIV], model.div_zero_count, model.op_count[OP_SUB],
               model.op_count[OP_NOT], model.op_count[OP_OR], model.op_count[OP_AND]);
      if (model.pending_results.size() != 0)
         $error("%0d results never arrived", model.pending_results.size());
      if (model.errors == 0 && model.pending_results.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // receiver stall pattern, with one long hold-off mid-run
   initial begin
      int mode;
      int len;
      @(posedge clock);
      forever begin
         if (!held_off && model.executed >= 600) begin
            held_off = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         mode = $urandom_range(0, 3);
         len = $urandom_range(5, 60);
         repeat (len) begin
            case (mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= 1'($urandom_range(0, 1));
               2:       rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= ($urandom_range(0, 7) != 0);
            endcase
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) model.compare(rsp_data);
         if (req_valid && req_ready) model.execute(req_data);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $error("no transaction for %0d cycles", IDLE_LIMIT);
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
